[src/uers_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uers_pkg
// Shared widths, register indexes and constants of the echo ranging block.
// ----------------------------------------------------------------------------
package uers_pkg;

  // channel payload widths
  localparam int EDGE_TIME_W = 63;
  localparam int DIST_W      = 16;
  localparam int SPEED_W     = 27;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_US_PER_CM       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_NS = 8'd1;

  // register reset values
  localparam logic [7:0]  US_PER_CM_RST       = 8'd58;
  localparam logic [31:0] MIN_INTERVAL_NS_RST = 32'd1000000;

  // arithmetic constants
  localparam logic [9:0]  NS_PER_US  = 10'd1000;
  localparam logic [3:0]  MM_PER_CM  = 4'd10;
  localparam logic [29:0] NS_PER_S   = 30'd1000000000;
  localparam logic [15:0] DIST_MAX   = 16'd65535;
  localparam logic [12:0] CM_SAT     = 13'd6553;
  localparam logic [25:0] SPEED_MAX  = 26'd65535000;

  // scale divisor (us_per_cm * 1000) and speed product (mm * 1e9) widths
  localparam int SCALE_W = 18;
  localparam int PROD_W  = 46;

endpackage

[src/uers_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uers_in_if
// Echo edge channel: level after the edge and its nanosecond timestamp.
// ----------------------------------------------------------------------------
interface uers_in_if;
  import uers_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   echo_level;
  logic [EDGE_TIME_W-1:0] edge_time_ns;

  modport source (output valid, output echo_level, output edge_time_ns, input ready);
  modport sink   (input valid, input echo_level, input edge_time_ns, output ready);
endinterface

[src/uers_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uers_out_if
// Measurement channel: distance, speed and speed update flag.
// ----------------------------------------------------------------------------
interface uers_out_if;
  import uers_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [DIST_W-1:0]         range_mm;
  logic signed [SPEED_W-1:0] velocity_mm_s;
  logic                      speed_updated;

  modport source (output valid, output range_mm, output velocity_mm_s,
                  output speed_updated, input ready);
  modport sink   (input valid, input range_mm, input velocity_mm_s,
                  input speed_updated, output ready);
endinterface

[src/uers_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uers_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface uers_cfg_if;
  import uers_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[src/ultrasonic_echo_range_and_speed_top.sv]
`timescale 1ns / 1ps
// A rising edge only stores its time. A falling edge is dropped if reversed or under one
// microsecond; else the distance is divided out (no division at zero scale), then the speed
// is divided out only when it is recomputed.
// Both divisions share one restoring divider, one quotient bit a cycle. A finished
// item waits in the output register; input stalls whenever the sequencer is not idle.
// Reset (rst_n low, synchronous) restores register defaults and clears the ranging state.
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_and_speed_top
// Echo pulse ranging: distance from pulse width, speed from distance change.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_and_speed_top #(
  parameter int TIME_BITS = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  uers_in_if.sink      in_ch,
  uers_out_if.source   out_ch,
  uers_cfg_if.sink     cfg_ch
);
  import uers_pkg::*;

  localparam int TB     = TIME_BITS;
  localparam int DW     = (TB > PROD_W) ? TB : PROD_W;
  localparam int CNT_W  = $clog2(DW + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CHK   = 7'b0000010,
    ST_DIV_D = 7'b0000100,
    ST_DSAT  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_DIV_S = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [7:0]  us_per_cm_r;
  logic [31:0] min_interval_r;

  // architectural state
  logic [TB-1:0]             rise_r;
  logic [DIST_W-1:0]         last_dist_r;
  logic [TB-1:0]             last_time_r;
  logic                      have_prev_r;
  logic signed [SPEED_W-1:0] held_r;

  // per-item work registers
  logic [TB-1:0]     t_r;
  logic [TB-1:0]     diff_r;
  logic              rev_r;
  logic [TB-1:0]     dt_r;
  logic              gt_r;
  logic              zk_r;
  logic [DIST_W-1:0] dist_r;
  logic              upd_r;
  logic              neg_r;

  // shared divider
  logic [TB-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [TB-1:0]    div_r;
  logic [CNT_W-1:0] cnt_r;

  // output register
  logic                      out_valid_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic signed [SPEED_W-1:0] out_speed_r;
  logic                      out_upd_r;

  logic              in_fire;
  logic              out_free;
  logic [TB-1:0]     in_t;
  logic [TB:0]       trial;
  logic [TB:0]       trial_sub;
  logic              trial_ge;
  logic [TB-1:0]     rem_step;
  logic [DW-1:0]     quo_step;
  logic              div_last;
  logic [SCALE_W-1:0] scale;
  logic [DW-1:0]     cm_q;
  logic [DIST_W-1:0] dist_calc;
  logic [DIST_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] spd_q;
  logic [25:0]       spd_mag;
  logic signed [SPEED_W-1:0] spd_nxt;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_t         = in_ch.edge_time_ns[TB-1:0];
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.range_mm      = out_dist_r;
  assign out_ch.velocity_mm_s = out_speed_r;
  assign out_ch.speed_updated = out_upd_r;

  // one restoring divide step
  assign trial     = {rem_r, quo_r[DW-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign trial_ge  = (trial >= {1'b0, div_r});
  assign rem_step  = trial_ge ? trial_sub[TB-1:0] : trial[TB-1:0];
  assign quo_step  = {quo_r[DW-2:0], trial_ge};
  assign div_last  = (cnt_r == CNT_W'(1));

  // echo time per centimetre in ns
  assign scale = SCALE_W'(us_per_cm_r) * SCALE_W'(NS_PER_US);

  // distance from centimetre quotient, saturated
  always_comb begin
    cm_q = quo_r;
    if (zk_r || (cm_q > DW'(CM_SAT))) begin
      dist_calc = DIST_MAX;
    end else begin
      dist_calc = DIST_W'(DIST_W'(cm_q[12:0]) * DIST_W'(MM_PER_CM));
    end
  end

  // distance change magnitude and its product with ns per second
  assign mag  = (dist_r < last_dist_r) ? (last_dist_r - dist_r) : (dist_r - last_dist_r);
  assign prod = PROD_W'(mag) * PROD_W'(NS_PER_S);

  // speed from quotient, saturated and signed; hold otherwise
  always_comb begin
    spd_q   = quo_r[PROD_W-1:0];
    spd_mag = (spd_q > PROD_W'(SPEED_MAX)) ? SPEED_MAX : spd_q[25:0];
    if (upd_r) begin
      spd_nxt = neg_r ? -$signed({1'b0, spd_mag}) : $signed({1'b0, spd_mag});
    end else begin
      spd_nxt = held_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_ch.echo_level) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (rev_r || (diff_r < TB'(NS_PER_US))) state_nxt = ST_IDLE;
        else if (us_per_cm_r == 8'd0)          state_nxt = ST_DSAT;
        else                                    state_nxt = ST_DIV_D;
      end
      ST_DIV_D: begin
        if (div_last) state_nxt = ST_DSAT;
      end
      ST_DSAT:  state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = upd_r ? ST_DIV_S : ST_FIN;
      end
      ST_DIV_S: begin
        if (div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      us_per_cm_r    <= US_PER_CM_RST;
      min_interval_r <= MIN_INTERVAL_NS_RST;
      rise_r         <= '0;
      last_dist_r    <= '0;
      last_time_r    <= '0;
      have_prev_r    <= 1'b0;
      held_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_US_PER_CM:       us_per_cm_r    <= cfg_ch.wdata[7:0];
          REG_MIN_INTERVAL_NS: min_interval_r <= cfg_ch.wdata;
          default: ;
        endcase
      end

      // store rise time
      if (in_fire && in_ch.echo_level) rise_r <= in_t;

      // commit measurement and load output; drop output once taken
      if ((state_r == ST_FIN) && out_free) begin
        held_r      <= spd_nxt;
        last_dist_r <= dist_r;
        last_time_r <= t_r;
        have_prev_r <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        t_r    <= in_t;
        diff_r <= in_t - rise_r;
        rev_r  <= (in_t < rise_r);
      end
      ST_CHK: begin
        dt_r  <= t_r - last_time_r;
        gt_r  <= (t_r > last_time_r);
        zk_r  <= (us_per_cm_r == 8'd0);
        rem_r <= '0;
        quo_r <= DW'(diff_r);
        div_r <= TB'(scale);
        cnt_r <= CNT_W'(DW);
      end
      ST_DIV_D, ST_DIV_S: begin
        rem_r <= rem_step;
        quo_r <= quo_step;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_DSAT: begin
        dist_r <= dist_calc;
        upd_r  <= have_prev_r && gt_r && (dt_r >= TB'(min_interval_r));
      end
      ST_MUL: begin
        neg_r <= (dist_r < last_dist_r);
        rem_r <= '0;
        quo_r <= DW'(prod) << (DW - PROD_W);
        div_r <= dt_r;
        cnt_r <= CNT_W'(PROD_W);
      end
      ST_FIN: begin
        if (out_free) begin
          out_dist_r  <= dist_r;
          out_speed_r <= spd_nxt;
          out_upd_r   <= upd_r;
        end
      end
      default: ;
    endcase
  end

  // partial remainder stays below the divisor while dividing
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV_D) || (state_r == ST_DIV_S)) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");

  // a waiting result always matches the held speed
  a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_speed_r == held_r))
    else $error("output speed differs from held speed");

  // reported speed stays within saturation limits
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_speed_r <= $signed({1'b0, SPEED_MAX}))
                     && (out_speed_r >= -$signed({1'b0, SPEED_MAX}))))
    else $error("speed outside saturation range");

  // a recomputed speed needs an earlier measurement
  a_upd_needs_prev: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV_S) |-> have_prev_r))
    else $error("speed division without previous measurement");

endmodule

[verif/echo_range_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_range_checker
// Watches the edge, measurement and register channels of the echo ranging
// block. It keeps its own copy of the registers and the ranging state, works
// out the measurement that each accepted falling edge gives and compares every
// accepted measurement field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module echo_range_checker (
  input  logic        clk,
  input  logic        rst_n,
  uers_in_if          in_ch,
  uers_out_if         out_ch,
  uers_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned meas_pending,
  output int unsigned meas_seen,
  output int unsigned speed_updates,
  output int unsigned dist_sats,
  output int unsigned speed_sats
);
  import uers_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]         range_mm;
    logic signed [SPEED_W-1:0] speed;
    logic                      updated;
  } echo_meas_t;

  // measurements predicted but not yet seen on the result channel
  echo_meas_t pending_meas[$];

  // register copies
  logic [7:0]  us_per_cm;
  logic [31:0] min_gap_ns;

  // ranging state
  logic [EDGE_TIME_W-1:0]    rise_ns;
  logic [EDGE_TIME_W-1:0]    last_meas_ns;
  logic [DIST_W-1:0]         last_dist;
  logic                      have_prev;
  logic signed [SPEED_W-1:0] held_speed;

  // distance in mm for a pulse width in whole microseconds
  function automatic logic [DIST_W-1:0] range_of(longint unsigned width_us);
    longint unsigned mm;
    if (us_per_cm == '0) return DIST_MAX;
    mm = (width_us / us_per_cm) * MM_PER_CM;
    return (mm > DIST_MAX) ? DIST_MAX : DIST_W'(mm);
  endfunction

  // apply one edge to the state; return 1 with the measurement if it gives one
  function automatic bit measure_edge(input logic lvl,
                                      input logic [EDGE_TIME_W-1:0] t,
                                      output echo_meas_t m);
    longint unsigned   width_us;
    longint unsigned   dt;
    longint unsigned   mag;
    longint unsigned   q;
    logic [DIST_W-1:0] cur_mm;
    logic              updated;
    m = '0;
    if (lvl) begin
      rise_ns = t;
      return 1'b0;
    end
    // drop reversed and sub-microsecond pulses without touching the state
    if (t < rise_ns) return 1'b0;
    width_us = (64'(t) - 64'(rise_ns)) / NS_PER_US;
    if (width_us == 0) return 1'b0;
    cur_mm  = range_of(width_us);
    updated = 1'b0;
    // recompute speed only on a later measurement far enough from the last
    if (have_prev && t > last_meas_ns) begin
      dt = 64'(t) - 64'(last_meas_ns);
      if (dt >= min_gap_ns) begin
        mag = (cur_mm >= last_dist) ? 64'(cur_mm - last_dist) : 64'(last_dist - cur_mm);
        q   = (mag * NS_PER_S) / dt;
        if (q > SPEED_MAX) q = SPEED_MAX;
        held_speed = (cur_mm < last_dist) ? -SPEED_W'(q) : SPEED_W'(q);
        updated    = 1'b1;
      end
    end
    last_dist    = cur_mm;
    last_meas_ns = t;
    have_prev    = 1'b1;
    m.range_mm = cur_mm;
    m.speed    = held_speed;
    m.updated  = updated;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    echo_meas_t got;
    echo_meas_t want;
    if (!rst_n) begin
      us_per_cm     = US_PER_CM_RST;
      min_gap_ns    = MIN_INTERVAL_NS_RST;
      rise_ns       = '0;
      last_meas_ns  = '0;
      last_dist     = '0;
      have_prev     = 1'b0;
      held_speed    = '0;
      pending_meas.delete();
      fail_count    = 0;
      meas_seen     = 0;
      speed_updates = 0;
      dist_sats     = 0;
      speed_sats    = 0;
    end else begin
      // compare a finished measurement with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        got.range_mm = out_ch.range_mm;
        got.speed    = out_ch.velocity_mm_s;
        got.updated  = out_ch.speed_updated;
        if (pending_meas.size() == 0) begin
          $error("measurement with none expected: range_mm %0d velocity_mm_s %0d",
                 got.range_mm, $signed(got.speed));
          fail_count++;
        end else begin
          want = pending_meas.pop_front();
          if (got.range_mm !== want.range_mm) begin
            $error("range_mm: expected %0d, got %0d", want.range_mm, got.range_mm);
            fail_count++;
          end
          if (got.speed !== want.speed) begin
            $error("velocity_mm_s: expected %0d, got %0d",
                   $signed(want.speed), $signed(got.speed));
            fail_count++;
          end
          if (got.updated !== want.updated) begin
            $error("speed_updated: expected %0d, got %0d", want.updated, got.updated);
            fail_count++;
          end
          meas_seen++;
          if (want.updated) speed_updates++;
          if (want.range_mm == DIST_MAX) dist_sats++;
          if (want.updated && (want.speed == SPEED_W'(SPEED_MAX) ||
                               want.speed == -SPEED_W'(SPEED_MAX)))
            speed_sats++;
        end
      end

      // track register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_US_PER_CM:       us_per_cm  = cfg_ch.wdata[7:0];
          REG_MIN_INTERVAL_NS: min_gap_ns = cfg_ch.wdata;
          default: ;
        endcase
      end

      // predict the result of an accepted edge
      if (in_ch.valid && in_ch.ready) begin
        if (measure_edge(in_ch.echo_level, in_ch.edge_time_ns, want))
          pending_meas.push_back(want);
      end
    end
    meas_pending = pending_meas.size();
  end

endmodule

[verif/ultrasonic_echo_range_and_speed_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_range_and_speed_top_tb
// Drives echo edges and register writes into the echo ranging block: a short
// directed run over the corner cases, then random rise/fall pairs with noise
// under several register settings and handshake idling patterns. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module ultrasonic_echo_range_and_speed_top_tb;
  import uers_pkg::*;

  localparam int IDLE_LIMIT    = 20000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SEG_ITEMS     = 310;
  localparam int NUM_SEGS      = 6;
  localparam longint unsigned T_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned TIME_CEIL = 64'h7FFF_FF00_0000_0000;
  localparam longint unsigned JUMP_MASK = 64'h7FFF_FEFF_FFFF_FFFF;

  logic clk;
  logic rst_n;

  uers_in_if  in_ch();
  uers_out_if out_ch();
  uers_cfg_if cfg_ch();

  int unsigned fail_count;
  int unsigned meas_pending;
  int unsigned meas_seen;
  int unsigned speed_updates;
  int unsigned dist_sats;
  int unsigned speed_sats;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 50;
  int unsigned hold_req      = 0;
  int unsigned edges_sent    = 0;
  int unsigned reg_writes    = 0;

  longint unsigned now_ns;
  longint unsigned last_rise_ns;
  longint unsigned cur_min_gap;
  logic [7:0]      cur_us_per_cm;

  ultrasonic_echo_range_and_speed_top #(
    .TIME_BITS(EDGE_TIME_W)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  echo_range_checker u_range_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .meas_pending (meas_pending),
    .meas_seen    (meas_seen),
    .speed_updates(speed_updates),
    .dist_sats    (dist_sats),
    .speed_sats   (speed_sats)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: end the run when no channel moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: %0d cycles without any handshake", IDLE_LIMIT);
    $display("ultrasonic_echo_range_and_speed_top verification failed");
    $finish;
  end

  // offer one edge item, with random idle cycles ahead of it
  task automatic send_edge(input logic lvl, input longint unsigned t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.echo_level   <= lvl;
    in_ch.edge_time_ns <= EDGE_TIME_W'(t);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    edges_sent++;
    if (lvl) last_rise_ns = t;
  endtask

  task automatic echo_pulse(input longint unsigned rise_t, input longint unsigned fall_t);
    send_edge(1'b1, rise_t);
    send_edge(1'b0, fall_t);
  endtask

  // drain the block, then write both registers back to back
  task automatic program_regs(input logic [7:0] us, input logic [31:0] gap);
    in_ch.valid <= 1'b0;
    wait (meas_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_US_PER_CM;
    cfg_ch.wdata     <= CFG_DATA_W'(us);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.reg_index <= REG_MIN_INTERVAL_NS;
    cfg_ch.wdata     <= gap;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid  <= 1'b0;
    reg_writes    += 2;
    cur_us_per_cm = us;
    cur_min_gap   = gap;
  endtask

  // one random step: mostly a well-formed rise/fall pair, sometimes noise
  task automatic random_step();
    longint unsigned width_ns;
    longint unsigned target;
    longint unsigned gap_ns;
    longint unsigned r;
    int unsigned     pick;
    int unsigned     mode;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
        // jump the time base anywhere, high bits included
        now_ns = {$urandom, $urandom} & JUMP_MASK;
      end else begin
        case (mode % 4)
          0: send_edge(1'b1, now_ns + $urandom_range(0, 100_000));
          1: begin
            // stray fall shortly after the last one
            now_ns += $urandom_range(0, 3000);
            send_edge(1'b0, now_ns);
          end
          2: send_edge(1'b1, {$urandom, $urandom} & T_MAX);
          default: send_edge(1'b0, (last_rise_ns > 1000) ?
                                   last_rise_ns - $urandom_range(1, 1000) : 0);
        endcase
      end
    end else begin
      // pulse width
      mode = $urandom_range(0, 99);
      if (mode < 8)
        width_ns = $urandom_range(0, 1999);
      else if (mode < 20)
        width_ns = longint'(6553 + $urandom_range(0, 1)) * cur_us_per_cm * NS_PER_US +
                   $urandom_range(0, 999);
      else if (mode < 30)
        width_ns = {$urandom_range(0, 3), $urandom};
      else if (mode < 60)
        width_ns = $urandom_range(1000, 400_000);
      else
        width_ns = $urandom_range(1000, 40_000_000);
      // interval from the last fall, aimed around the speed threshold
      mode = $urandom_range(0, 99);
      r    = $urandom_range(0, 2000);
      if (mode < 12)
        target = (cur_min_gap > 0) ? cur_min_gap + $urandom_range(0, 2) - 1 : 0;
      else if (mode < 30)
        target = (cur_min_gap + r > 1000) ? cur_min_gap + r - 1000 : 0;
      else if (mode < 55)
        target = {$urandom, $urandom} % (2 * cur_min_gap + 1);
      else if (mode < 80)
        target = cur_min_gap + $urandom_range(0, 50_000_000);
      else
        target = $urandom_range(0, 100_000);
      gap_ns = (target > width_ns) ? target - width_ns : $urandom_range(0, 1000);
      echo_pulse(now_ns + gap_ns, now_ns + gap_ns + width_ns);
      now_ns += gap_ns + width_ns;
    end
    if (now_ns > TIME_CEIL) now_ns = $urandom_range(0, 1_000_000);
  endtask

  // stimulus and verdict
  initial begin
    int unsigned seg_end;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.echo_level   = 1'b0;
    in_ch.edge_time_ns = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = REG_US_PER_CM;
    cfg_ch.wdata       = '0;
    cur_us_per_cm      = US_PER_CM_RST;
    cur_min_gap        = MIN_INTERVAL_NS_RST;
    now_ns             = 0;
    last_rise_ns       = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset register values
    send_edge(1'b0, 0);                           // fall at time zero, zero width
    echo_pulse(1000, 1999);                       // just under one microsecond
    echo_pulse(5000, 4000);                       // fall before rise
    echo_pulse(10_000, 68_000);                   // first measurement, speed held
    echo_pulse(100_000, 680_000);                 // interval below threshold
    echo_pulse(2_000_000, 402_000_000);           // distance saturates, speed updates
    echo_pulse(2_000_000, 402_000_000);           // same fall time: zero interval
    echo_pulse(1000, 59_000);                     // earlier than last measurement
    echo_pulse(T_MAX - 1_000_000, T_MAX);         // top of the time range
    echo_pulse(T_MAX, T_MAX);

    // directed, finest scale and no interval threshold
    program_regs(8'd1, 32'd0);
    echo_pulse(0, 1000);
    echo_pulse(0, 6_554_000);
    echo_pulse(5_000_000, 6_554_010);             // negative speed overflow
    echo_pulse(0, 6_554_020);                     // positive speed overflow
    echo_pulse(6_554_020, 6_555_020);
    echo_pulse(6_555_020, 6_556_019);

    // directed, zero scale and widest threshold
    program_regs(8'd0, 32'hFFFF_FFFF);
    echo_pulse(7_000_000, 7_001_000);
    echo_pulse(7_000_000, 5_007_000_000);
    echo_pulse(64'h5555_5555_5555_5555, 64'h2AAA_AAAA_AAAA_AAAA);
    echo_pulse(64'h2AAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    // random segments
    now_ns = 64'd8_000_000_000;
    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: program_regs(US_PER_CM_RST, MIN_INTERVAL_NS_RST);
        1: program_regs(8'd1, 32'd0);
        2: program_regs(8'd255, 32'hFFFF_FFFF);
        3: program_regs(8'($urandom_range(1, 255)), $urandom_range(0, 50_000_000));
        4: program_regs(8'($urandom_range(0, 255)), $urandom);
        default: program_regs(8'($urandom_range(2, 20)), $urandom_range(0, 5000));
      endcase
      if (seg < 2) begin
        send_idle_pct = 9;
        recv_idle_pct = 50;
      end else if (seg < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // stall the result side while edges keep coming
      if (seg == 4) hold_req++;
      seg_end = edges_sent + SEG_ITEMS;
      while (edges_sent < seg_end) random_step();
    end

    // drain and give the verdict
    in_ch.valid <= 1'b0;
    wait (meas_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d echo edges and %0d register writes; %0d measurements checked",
             edges_sent, reg_writes, meas_seen);
    $display("%0d speed recomputes, %0d saturated distances, %0d saturated speeds",
             speed_updates, dist_sats, speed_sats);
    if (fail_count == 0 && meas_pending == 0)
      $display("ultrasonic_echo_range_and_speed_top verification clean");
    else
      $display("ultrasonic_echo_range_and_speed_top verification failed");
    $finish;
  end

endmodule
